/* rtl/core/tccw_pkg.sv */
// Package for the text console character writer: operation classes, queue entry,
// status structs and character constants. No dependencies.
package tccw_pkg;

    localparam int FUNC_W = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int QDEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TILDE  = 8'h7E;
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;

    localparam logic [CHAR_W-1:0] COLOR_RESET = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_CELL  = {COLOR_RESET, CH_BLANK};

    typedef enum logic [3:0] {
        OP_PRINT,
        OP_NEWLINE,
        OP_VTAB,
        OP_TAB,
        OP_DEL,
        OP_IGNORE,
        OP_READ,
        OP_READ_NONE,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL,
        ST_COPY,
        ST_BLANK
    } state_t;

endpackage

/* rtl/core/tccw_front.sv */
// Front end of the text console writer: accepts commands and sorts each into an
// operation class for the queue. Depends on tccw_pkg.
module tccw_front #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         start,
    output logic                         busy,
    input  logic [tccw_pkg::FUNC_W-1:0]  func,
    input  logic [tccw_pkg::CHAR_W-1:0]  char_code,
    input  logic [tccw_pkg::ROW_W-1:0]   read_row,
    input  logic [tccw_pkg::COL_W-1:0]   read_col,
    input  tccw_pkg::q_status_t          q_status,
    input  logic                         init_busy,
    output logic                         push,
    output tccw_pkg::entry_t             entry
);

    tccw_pkg::op_t op;

    assign busy = q_status.full | init_busy;
    assign push = start & ~busy;

    always_comb
    begin
        op = tccw_pkg::OP_NOP;
        case (func)
            tccw_pkg::FUNC_PUT:
            begin
                if (((char_code >= tccw_pkg::CH_BLANK) && (char_code <= tccw_pkg::CH_TILDE))
                    || (char_code == tccw_pkg::CH_FF))
                    op = tccw_pkg::OP_PRINT;
                else if ((char_code == tccw_pkg::CH_CR) || (char_code == tccw_pkg::CH_LF))
                    op = tccw_pkg::OP_NEWLINE;
                else if (char_code == tccw_pkg::CH_VT)
                    op = tccw_pkg::OP_VTAB;
                else if (char_code == tccw_pkg::CH_TAB)
                    op = tccw_pkg::OP_TAB;
                else if (char_code == tccw_pkg::CH_DEL)
                    op = tccw_pkg::OP_DEL;
                else
                    op = tccw_pkg::OP_IGNORE;
            end
            tccw_pkg::FUNC_READ:
            begin
                if ((int'(read_row) < ROWS) && (int'(read_col) < COLUMNS))
                    op = tccw_pkg::OP_READ;
                else
                    op = tccw_pkg::OP_READ_NONE;
            end
            tccw_pkg::FUNC_CLEAR:
                op = tccw_pkg::OP_CLEAR;
            default:
                op = tccw_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        entry.op  = op;
        entry.ch  = char_code;
        entry.row = read_row;
        entry.col = read_col;
    end

endmodule

/* rtl/core/tccw_queue.sv */
// Short queue of classified operations between the front and back ends.
// Depends on tccw_pkg.
module tccw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tccw_pkg::entry_t    push_entry,
    input  logic                pop,
    output tccw_pkg::entry_t    head_entry,
    output tccw_pkg::q_status_t q_status
);

    localparam int PW = (tccw_pkg::QDEPTH > 1) ? $clog2(tccw_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(tccw_pkg::QDEPTH + 1);

    tccw_pkg::entry_t slot_reg [tccw_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_status.full  = (count_reg == CW'(tccw_pkg::QDEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push = push & ~q_status.full;
    assign do_pop  = pop & ~q_status.empty;
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(tccw_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(tccw_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

/* rtl/core/tccw_back.sv */
// Back end of the text console writer: cursor, cell memory and the sequencer for
// writes, reads, clears, scrolls and the clearing pass after reset. Depends on tccw_pkg.
module tccw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tccw_pkg::CHAR_W-1:0]   text_color,
    input  tccw_pkg::entry_t              head_entry,
    input  tccw_pkg::q_status_t           q_status,
    output logic                          pop,
    output logic                          init_busy,
    output logic                          done,
    output logic [tccw_pkg::CELL_W-1:0]   cell_data,
    output logic [tccw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tccw_pkg::COL_W-1:0]    cursor_col,
    output logic                          scrolled,
    output logic                          ignored
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW1   = RW + 1;
    localparam int CW1   = CW + 1;
    localparam int OUT_ROW_W = tccw_pkg::ROW_W;
    localparam int OUT_COL_W = tccw_pkg::COL_W;

    function automatic logic [AW-1:0] cell_addr(input int r, input int c);
        return AW'(r * COLUMNS + c);
    endfunction

    logic [tccw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tccw_pkg::CELL_W-1:0] rdata_reg;

    tccw_pkg::state_t state_reg, state_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic          copy_pend_reg, copy_pend_next;
    logic [AW-1:0] copy_dst_reg, copy_dst_next;
    logic          done_reg, done_next;
    logic [tccw_pkg::CELL_W-1:0] cell_data_reg, cell_data_next;
    logic          scrolled_reg, scrolled_next;
    logic          ignored_reg, ignored_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [tccw_pkg::CELL_W-1:0] mem_wdata;

    logic [RW1-1:0] nrow;
    logic [CW1-1:0] ncol;
    logic           is_put, put_ign;
    logic [tccw_pkg::CELL_W-1:0] blank_cell;

    assign blank_cell = {text_color, tccw_pkg::CH_BLANK};
    assign init_busy  = (state_reg == tccw_pkg::ST_INIT);
    assign done       = done_reg;
    assign cell_data  = cell_data_reg;
    assign scrolled   = scrolled_reg;
    assign ignored    = ignored_reg;
    assign cursor_row = OUT_ROW_W'(cur_row_reg);
    assign cursor_col = OUT_COL_W'(cur_col_reg);

    always_comb
    begin
        state_next     = state_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        cnt_next       = cnt_reg;
        copy_pend_next = 1'b0;
        copy_dst_next  = copy_dst_reg;
        done_next      = 1'b0;
        cell_data_next = cell_data_reg;
        scrolled_next  = scrolled_reg;
        ignored_next   = ignored_reg;
        pop            = 1'b0;
        mem_we         = copy_pend_reg;
        mem_waddr      = copy_dst_reg;
        mem_wdata      = rdata_reg;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        nrow           = {1'b0, cur_row_reg};
        ncol           = {1'b0, cur_col_reg};
        is_put         = 1'b0;
        put_ign        = 1'b0;

        case (state_reg)
            tccw_pkg::ST_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = tccw_pkg::RESET_CELL;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    case (head_entry.op)
                        tccw_pkg::OP_PRINT:
                        begin
                            is_put    = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = cell_addr(int'(cur_row_reg), int'(cur_col_reg));
                            mem_wdata = {text_color, head_entry.ch};
                            ncol      = ncol + 1'b1;
                        end
                        tccw_pkg::OP_NEWLINE:
                        begin
                            is_put = 1'b1;
                            ncol   = '0;
                            nrow   = nrow + 1'b1;
                        end
                        tccw_pkg::OP_VTAB:
                        begin
                            is_put = 1'b1;
                            nrow   = nrow + 1'b1;
                        end
                        tccw_pkg::OP_TAB:
                        begin
                            is_put = 1'b1;
                            ncol   = (ncol + CW1'(4)) & ~CW1'(3);
                        end
                        tccw_pkg::OP_DEL:
                        begin
                            is_put = 1'b1;
                            if (cur_col_reg == '0)
                                put_ign = 1'b1;
                            else
                            begin
                                ncol      = ncol - 1'b1;
                                mem_we    = 1'b1;
                                mem_waddr = cell_addr(int'(cur_row_reg),
                                                      int'(cur_col_reg) - 1);
                                mem_wdata = blank_cell;
                            end
                        end
                        tccw_pkg::OP_IGNORE:
                        begin
                            is_put  = 1'b1;
                            put_ign = 1'b1;
                        end
                        tccw_pkg::OP_READ:
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cell_addr(int'(head_entry.row), int'(head_entry.col));
                            state_next = tccw_pkg::ST_READ;
                        end
                        tccw_pkg::OP_READ_NONE:
                        begin
                            done_next      = 1'b1;
                            cell_data_next = '0;
                            scrolled_next  = 1'b0;
                            ignored_next   = 1'b0;
                        end
                        tccw_pkg::OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = tccw_pkg::ST_FILL;
                        end
                        default:
                        begin
                            done_next      = 1'b1;
                            cell_data_next = '0;
                            scrolled_next  = 1'b0;
                            ignored_next   = 1'b0;
                        end
                    endcase

                    if (is_put)
                    begin
                        if (ncol >= CW1'(COLUMNS))
                        begin
                            ncol = '0;
                            nrow = nrow + 1'b1;
                        end
                        cur_col_next   = CW'(ncol);
                        cell_data_next = '0;
                        ignored_next   = put_ign;
                        scrolled_next  = 1'b0;
                        if (nrow >= RW1'(ROWS))
                        begin
                            cur_row_next = RW'(ROWS - 1);
                            cnt_next     = '0;
                            state_next   = tccw_pkg::ST_COPY;
                        end
                        else
                        begin
                            cur_row_next = RW'(nrow);
                            done_next    = 1'b1;
                        end
                    end
                end
            end
            tccw_pkg::ST_READ:
            begin
                done_next      = 1'b1;
                cell_data_next = rdata_reg;
                scrolled_next  = 1'b0;
                ignored_next   = 1'b0;
                state_next     = tccw_pkg::ST_IDLE;
            end
            tccw_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = blank_cell;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next       = '0;
                    done_next      = 1'b1;
                    cell_data_next = '0;
                    scrolled_next  = 1'b0;
                    ignored_next   = 1'b0;
                    state_next     = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_COPY:
            begin
                mem_re         = 1'b1;
                mem_raddr      = cnt_reg + AW'(COLUMNS);
                copy_pend_next = 1'b1;
                copy_dst_next  = cnt_reg;
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == AW'(CELLS - COLUMNS - 1))
                    state_next = tccw_pkg::ST_BLANK;
            end
            tccw_pkg::ST_BLANK:
            begin
                if (!copy_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_reg;
                    mem_wdata = blank_cell;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == AW'(CELLS - 1))
                    begin
                        cnt_next       = '0;
                        done_next      = 1'b1;
                        cell_data_next = '0;
                        scrolled_next  = 1'b1;
                        ignored_next   = 1'b0;
                        state_next     = tccw_pkg::ST_IDLE;
                    end
                end
            end
            default:
                state_next = tccw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tccw_pkg::ST_INIT;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            cnt_reg       <= '0;
            copy_pend_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            cnt_reg       <= cnt_next;
            copy_pend_reg <= copy_pend_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg  <= copy_dst_next;
        cell_data_reg <= cell_data_next;
        scrolled_reg  <= scrolled_next;
        ignored_reg   <= ignored_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_raddr];
    end

endmodule

/* rtl/core/text_console_char_writer.sv */
// Top level of the text console character writer: colour register on the APB port,
// front end, operation queue and back end. Depends on tccw_pkg, tccw_front,
// tccw_queue and tccw_back.
//
//   Channel     Handshake                         Payload
//   command     start in, busy out                func, char_code, read_row, read_col
//   result      done strobe, one cycle            cell_data, cursor_row, cursor_col,
//                                                 scrolled, ignored
//   register    psel, penable, pwrite, pready     paddr, pwdata, prdata
//
// A plain put or a read out of range passes through a queue slot and then the result
// registers; an in-range read also passes the registered read port. A clear writes
// every cell in turn through the single write port. A put that scrolls copies the store
// up one cell a cycle through the registered read port and then blanks the last row.
// After reset a clearing pass holds busy high. The receiver cannot stall:
// each word is on the result ports for one cycle only.
module text_console_char_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tccw_pkg::FUNC_W-1:0]   func,
    input  logic [tccw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tccw_pkg::ROW_W-1:0]    read_row,
    input  logic [tccw_pkg::COL_W-1:0]    read_col,
    output logic                          done,
    output logic [tccw_pkg::CELL_W-1:0]   cell_data,
    output logic [tccw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tccw_pkg::COL_W-1:0]    cursor_col,
    output logic                          scrolled,
    output logic                          ignored,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [tccw_pkg::CHAR_W-1:0] text_color_reg, text_color_next;
    tccw_pkg::q_status_t q_status;
    tccw_pkg::entry_t    push_entry;
    tccw_pkg::entry_t    head_entry;
    logic                push;
    logic                pop;
    logic                init_busy;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {24'd0, text_color_reg} : 32'd0;

    always_comb
    begin
        text_color_next = text_color_reg;
        if (psel && penable && pwrite && pready && reg_sel)
            text_color_next = pwdata[tccw_pkg::CHAR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_color_reg <= tccw_pkg::COLOR_RESET;
        else
            text_color_reg <= text_color_next;
    end

    tccw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start     (start),
        .busy      (busy),
        .func      (func),
        .char_code (char_code),
        .read_row  (read_row),
        .read_col  (read_col),
        .q_status  (q_status),
        .init_busy (init_busy),
        .push      (push),
        .entry     (push_entry)
    );

    tccw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_status   (q_status)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_color (text_color_reg),
        .head_entry (head_entry),
        .q_status   (q_status),
        .pop        (pop),
        .init_busy  (init_busy),
        .done       (done),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .ignored    (ignored)
    );

endmodule

/* verif/tb_text_console_char_writer.sv */
// Self-checking testbench for text_console_char_writer: directed and random command words
// checked against a behavioural model of the screen store and cursor.
// Depends on tccw_pkg and the RTL of text_console_char_writer.
module tb_text_console_char_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tccw_pkg::*;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [2:0]        REG_TEXT_COLOR = 3'd0;

    typedef struct packed {
        logic [CELL_W-1:0] data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              scr;
        logic              ign;
    } console_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [FUNC_W-1:0]   func = '0;
    logic [CHAR_W-1:0]   char_code = '0;
    logic [ROW_W-1:0]    read_row = '0;
    logic [COL_W-1:0]    read_col = '0;
    logic                done;
    logic [CELL_W-1:0]   cell_data;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic                scrolled;
    logic                ignored;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    logic [CELL_W-1:0]   screen_cells [CELLS];
    int                  cur_r;
    int                  cur_c;
    logic [CHAR_W-1:0]   colour_reg;
    console_word_t       expected_words [$];
    int                  error_count = 0;
    bit                  idle_on = 1'b1;

    text_console_char_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .char_code  (char_code),
        .read_row   (read_row),
        .read_col   (read_col),
        .done       (done),
        .cell_data  (cell_data),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .scrolled   (scrolled),
        .ignored    (ignored),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    task automatic blank_rows(input int first_cell);
        for (int i = first_cell; i < CELLS; i++)
            screen_cells[i] = {colour_reg, CH_BLANK};
    endtask

    task automatic console_put(input logic [CHAR_W-1:0] code, output logic scr,
                               output logic ign);
        bit printable;
        bit space;
        printable = (code >= CH_BLANK) && (code <= CH_TILDE);
        space     = (code >= CH_TAB) && (code <= CH_CR);
        scr = 1'b0;
        ign = 1'b0;
        if (!printable && !space && code != CH_DEL)
        begin
            ign = 1'b1;
            return;
        end
        case (code)
            CH_CR, CH_LF:
            begin
                cur_c = 0;
                cur_r++;
            end
            CH_VT:
                cur_r++;
            CH_TAB:
                cur_c = (cur_c + 4) & ~3;
            CH_DEL:
            begin
                if (cur_c == 0)
                begin
                    ign = 1'b1;
                    return;
                end
                cur_c--;
                screen_cells[cur_r * COLUMNS + cur_c] = {colour_reg, CH_BLANK};
            end
            default:
            begin
                screen_cells[cur_r * COLUMNS + cur_c] = {colour_reg, code};
                cur_c++;
            end
        endcase
        if (cur_c >= COLUMNS)
        begin
            cur_c = 0;
            cur_r++;
        end
        if (cur_r >= ROWS)
        begin
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_cells[i] = screen_cells[i + COLUMNS];
            blank_rows(CELLS - COLUMNS);
            cur_r = ROWS - 1;
            scr = 1'b1;
        end
    endtask

    task automatic console_update(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] code,
                                  input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        console_word_t w;
        w = '0;
        case (f)
            FUNC_PUT:
                console_put(code, w.scr, w.ign);
            FUNC_READ:
                if (row < ROWS && col < COLUMNS)
                    w.data = screen_cells[row * COLUMNS + col];
            FUNC_CLEAR:
                blank_rows(0);
            default: ;
        endcase
        w.row = cur_r[ROW_W-1:0];
        w.col = cur_c[COL_W-1:0];
        expected_words.push_back(w);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance with start
    // still high, so that the next word can follow without a gap.
    task automatic send_word(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] code,
                             input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        char_code <= code;
        read_row  <= row;
        read_col  <= col;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        console_update(f, code, row, col);
        @(negedge clk);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_word(FUNC_PUT, code, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        send_word(FUNC_READ, CHAR_W'($urandom), row, col);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0 || busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_colour(input logic [CHAR_W-1:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= REG_TEXT_COLOR;
        pwdata  <= ($urandom & 32'hFFFF_FF00) | {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        colour_reg = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic test_reset_contents();
        read_cell('0, '0);
        read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        read_cell(ROW_W'(ROWS), '0);
        read_cell(5'h1F, 7'h7F);
        read_cell('0, COL_W'(COLUMNS));
        send_word(FUNC_UNUSED, 8'hFF, 5'h1F, 7'h7F);
    endtask

    task automatic test_put_bytes();
        put_char(CH_BLANK);
        put_char(CH_TILDE);
        put_char(CH_FF);
        put_char(8'h00);
        put_char(8'h08);
        put_char(8'h0E);
        put_char(8'h1F);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(CH_TAB);
        put_char(CH_DEL);
        put_char(CH_CR);
        put_char(CH_DEL);
        put_char(CH_VT);
        put_char(CH_LF);
        read_cell(5'd0, 7'd1);
        read_cell(5'd0, 7'd3);
    endtask

    task automatic test_colour_extremes();
        wait_idle();
        write_colour(8'h00);
        put_char(8'h41);
        read_cell(ROW_W'(cur_r), COL_W'(cur_c - 1));
        wait_idle();
        write_colour(8'hFF);
        send_word(FUNC_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
        read_cell('0, '0);
        read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    endtask

    task automatic test_random_text(input logic [CHAR_W-1:0] colour, input int count);
        int pick;
        logic [CHAR_W-1:0] code;
        wait_idle();
        write_colour(colour);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                put_char(CHAR_W'($urandom_range(CH_BLANK, CH_TILDE)));
            else if (pick < 60)
            begin
                code = CHAR_W'($urandom_range(CH_TAB, CH_CR + 1));
                put_char(code > CH_CR ? CH_DEL : code);
            end
            else if (pick < 64)
                put_char(CHAR_W'($urandom));
            else if (pick < 85)
            begin
                if ($urandom_range(0, 7) == 0)
                    read_cell(ROW_W'($urandom), COL_W'($urandom));
                else
                    read_cell(ROW_W'($urandom_range(0, ROWS - 1)),
                              COL_W'($urandom_range(0, COLUMNS - 1)));
            end
            else if (pick < 92)
                read_cell(ROW_W'(cur_r), COL_W'((cur_c == 0) ? 0 : cur_c - 1));
            else if (pick < 94)
                send_word(FUNC_CLEAR, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            else
                send_word(FUNC_W'($urandom), CHAR_W'($urandom), ROW_W'($urandom),
                          COL_W'($urandom));
        end
    endtask

    function automatic void compare_field(input string name, input logic [CELL_W-1:0] want,
                                          input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        console_word_t want;
        if (rst_n && done)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %0h %0d %0d %b %b",
                         $time, cell_data, cursor_row, cursor_col, scrolled, ignored);
                error_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("cell_data", want.data, cell_data);
                compare_field("cursor_row", CELL_W'(want.row), CELL_W'(cursor_row));
                compare_field("cursor_col", CELL_W'(want.col), CELL_W'(cursor_col));
                compare_field("scrolled", CELL_W'(want.scr), CELL_W'(scrolled));
                compare_field("ignored", CELL_W'(want.ign), CELL_W'(ignored));
            end
        end
    end

    initial
    begin
        colour_reg = COLOR_RESET;
        cur_r = 0;
        cur_c = 0;
        blank_rows(0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_contents();
        test_put_bytes();
        test_colour_extremes();
        test_random_text(8'h07, 100);
        test_random_text(8'h00, 100);
        test_random_text(8'hFF, 100);
        test_random_text(CHAR_W'($urandom), 100);
        idle_on = 1'b0;
        test_random_text(CHAR_W'($urandom), 100);

        wait_idle();
        repeat (16) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
